@@ hw/rtl/tfcm_pkg.sv @@
package tfcm_pkg;

  localparam int CHAN_W  = 8;
  localparam int INTEN_W = 10;

  // Kind of word on the input channel
  localparam logic CMD_MEASURE = 1'b0;
  localparam logic CMD_MAP     = 1'b1;

  typedef struct packed {
    logic accept;
    logic div_step;
    logic band_load;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic map_item;
    logic q_fixed;
  } ctrl_stat_t;

  // One entry of the Gaussian blue ramp, exp(-50 (0.6 - v)^2) scaled to 255,
  // built from a truncated series and eight squarings in Q30. Evaluated only
  // while the ROM is elaborated.
  function automatic logic [7:0] gauss_entry(int unsigned frac_bits, longint unsigned q);
    longint unsigned one;
    longint unsigned u;
    longint unsigned s;
    longint unsigned y;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned z3;
    longint unsigned e;
    longint unsigned res;
    one = 64'd1 << 30;
    u   = (64'd3 << frac_bits) - 64'd5 * q;
    s   = 64'd2 * u * u;
    if (s >= (64'd6 << (2 * frac_bits))) begin
      return 8'd0;
    end
    if (2 * frac_bits >= 30) begin
      y = s >> (2 * frac_bits - 30);
    end else begin
      y = s << (30 - 2 * frac_bits);
    end
    z  = y >> 8;
    z2 = (z * z) >> 30;
    z3 = (z2 * z) >> 30;
    e  = one - z + z2 / 64'd2 - z3 / 64'd6;
    for (int i = 0; i < 8; i++) begin
      e = (e * e) >> 30;
    end
    res = (e * 64'd255) >> 30;
    return res[7:0];
  endfunction

endpackage

@@ hw/rtl/thermal_false_color_map.sv @@
// Thermal false-color mapper. A frame is sent twice over the input stream.
// Words tagged as measure (in_tuser bit 0 low) fold each pixel's intensity
// into a stored minimum and maximum; in_tuser bit 1 marks the first pixel
// of that pass and restarts the range. Words tagged as map produce one
// output word each: the intensity normalized against the stored range and
// turned into a jet-style color (Gaussian blue ramp, then linear ramps
// through cyan, yellow and red). Measure words produce no output.
// The single configuration bit selects color intensity (r+g+b) or grey
// intensity (3*red); write it only while the block is idle.
// Timing: measure words are taken back to back while the block is idle. A
// map word inside the range runs a restoring divider that yields one quotient
// bit per cycle, then a band-select step, then the color step that loads the
// output register; in_tready stays low from acceptance until that load.
// Map words that clip to a range end or meet a flat or empty range skip the divider.
// The result sits in an output register; if the receiver stalls, the block
// keeps accepting measure words, and a following map word waits only at
// its final stage until the held word is taken. Reset clears the range to
// empty (minimum 1023, maximum 0), selects grey mode and drops out_tvalid.
module thermal_false_color_map #(
  parameter int FRAC_BITS = 10
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // red [7:0], green [15:8], blue [23:16]
  input  logic [1:0]  in_tuser,   // command [0], first_pixel [1]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata   // out_red [7:0], out_green [15:8], out_blue [23:16]
);
  import tfcm_pkg::*;

  ctrl_cmd_t          cmd;
  ctrl_stat_t         stat;
  logic [CHAN_W-1:0]  map_red;
  logic [CHAN_W-1:0]  map_green;
  logic [CHAN_W-1:0]  map_blue;

  // Sequencer: accept, divide, band select, output hand-off.
  tfcm_ctrl #(
    .FRAC_BITS (FRAC_BITS)
  ) u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Range registers, divider, band logic, Gaussian ROM and output register.
  tfcm_datapath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_command     (in_tuser[0]),
    .in_first_pixel (in_tuser[1]),
    .in_red         (in_tdata[7:0]),
    .in_green       (in_tdata[15:8]),
    .in_blue        (in_tdata[23:16]),
    .cmd            (cmd),
    .stat           (stat),
    .out_red        (map_red),
    .out_green      (map_green),
    .out_blue       (map_blue)
  );

  assign out_tdata = {map_blue, map_green, map_red};

endmodule

@@ hw/rtl/tfcm_ctrl.sv @@
module tfcm_ctrl #(
  parameter int FRAC_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  tfcm_pkg::ctrl_stat_t  stat,
  output tfcm_pkg::ctrl_cmd_t   cmd
);
  import tfcm_pkg::*;

  localparam int CNT_W = $clog2(FRAC_BITS);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_BAND,
    S_COLOR
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             in_tready_r, in_tready_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;

  always_comb begin
    cmd.accept    = in_tvalid && in_tready_r;
    cmd.div_step  = (state_r == S_DIV);
    cmd.band_load = (state_r == S_BAND);
    cmd.out_load  = (state_r == S_COLOR) && (!out_tvalid_r || out_tready);
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    in_tready_nxt = in_tready_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd.accept && stat.map_item) begin
          in_tready_nxt = 1'b0;
          count_nxt     = '0;
          state_nxt     = stat.q_fixed ? S_BAND : S_DIV;
        end
      end
      S_DIV: begin
        count_nxt = count_r + CNT_W'(1);
        if (count_r == CNT_W'(FRAC_BITS - 1)) begin
          state_nxt = S_BAND;
        end
      end
      S_BAND: begin
        state_nxt = S_COLOR;
      end
      S_COLOR: begin
        if (cmd.out_load) begin
          in_tready_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cmd.out_load) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      count_r      <= '0;
      in_tready_r  <= 1'b1;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      count_r      <= count_nxt;
      in_tready_r  <= in_tready_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  assign in_tready  = in_tready_r;
  assign out_tvalid = out_tvalid_r;

endmodule

@@ hw/rtl/tfcm_datapath.sv @@
module tfcm_datapath #(
  parameter int FRAC_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic                          cfg_wr_data,
  input  logic                          in_command,
  input  logic                          in_first_pixel,
  input  logic [tfcm_pkg::CHAN_W-1:0]   in_red,
  input  logic [tfcm_pkg::CHAN_W-1:0]   in_green,
  input  logic [tfcm_pkg::CHAN_W-1:0]   in_blue,
  input  tfcm_pkg::ctrl_cmd_t           cmd,
  output tfcm_pkg::ctrl_stat_t          stat,
  output logic [tfcm_pkg::CHAN_W-1:0]   out_red,
  output logic [tfcm_pkg::CHAN_W-1:0]   out_green,
  output logic [tfcm_pkg::CHAN_W-1:0]   out_blue
);
  import tfcm_pkg::*;

  localparam int Q_W         = FRAC_BITS + 1;
  localparam int T_W         = FRAC_BITS + 4;
  localparam int PROD_W      = FRAC_BITS + 9;
  localparam int UNIT        = 1 << FRAC_BITS;
  localparam int GAUSS_DEPTH = (6 * UNIT + 9) / 10;
  localparam int ADDR_W      = $clog2(GAUSS_DEPTH);

  localparam logic [T_W-1:0] T6  = T_W'(6 * UNIT);
  localparam logic [T_W-1:0] T7  = T_W'(7 * UNIT);
  localparam logic [T_W-1:0] T8  = T_W'(8 * UNIT);
  localparam logic [T_W-1:0] T9  = T_W'(9 * UNIT);
  localparam logic [T_W-1:0] T10 = T_W'(10 * UNIT);

  typedef enum logic [2:0] {
    BAND_GAUSS,
    BAND_G_UP,
    BAND_B_DOWN,
    BAND_R_UP,
    BAND_G_DOWN,
    BAND_RED
  } band_t;

  typedef logic [CHAN_W-1:0] rom_t [GAUSS_DEPTH];

  function automatic rom_t build_rom();
    rom_t rom;
    for (int i = 0; i < GAUSS_DEPTH; i++) begin
      rom[i] = gauss_entry(FRAC_BITS, longint'(i));
    end
    return rom;
  endfunction

  localparam rom_t GAUSS_ROM = build_rom();

  logic                color_mode_r;
  logic [INTEN_W-1:0]  range_low_r;
  logic [INTEN_W-1:0]  range_high_r;
  logic [INTEN_W-1:0]  rem_r;
  logic [INTEN_W-1:0]  div_r;
  logic [Q_W-1:0]      q_r;
  band_t               band_r;
  logic [Q_W-1:0]      d_r;
  logic [CHAN_W-1:0]   rom_q_r;
  logic [CHAN_W-1:0]   out_red_r;
  logic [CHAN_W-1:0]   out_green_r;
  logic [CHAN_W-1:0]   out_blue_r;

  logic [INTEN_W-1:0]  inten;
  logic                degenerate;
  logic                at_top;
  logic                at_bottom;
  logic [INTEN_W:0]    rem_sh;
  logic                div_ge;
  logic [T_W-1:0]      t_val;
  band_t               band_nxt;
  logic [T_W-1:0]      d_full;
  logic [PROD_W-1:0]   ramp_prod;
  logic [CHAN_W-1:0]   ramp;

  // Intensity: sum of channels in color mode, three times red otherwise
  always_comb begin
    if (color_mode_r) begin
      inten = INTEN_W'(in_red) + INTEN_W'(in_green) + INTEN_W'(in_blue);
    end else begin
      inten = (INTEN_W'(in_red) << 1) + INTEN_W'(in_red);
    end
    degenerate    = (range_high_r <= range_low_r);
    at_top        = (inten >= range_high_r);
    at_bottom     = (inten <= range_low_r);
    stat.map_item = (in_command == CMD_MAP);
    stat.q_fixed  = degenerate || at_top || at_bottom;
  end

  // One quotient bit per step of the restoring divider
  always_comb begin
    rem_sh = {rem_r, 1'b0};
    div_ge = (rem_sh >= {1'b0, div_r});
  end

  always_comb begin
    t_val  = (T_W'(q_r) << 3) + (T_W'(q_r) << 1);
    d_full = '0;
    if (t_val < T6) begin
      band_nxt = BAND_GAUSS;
    end else if (t_val < T7) begin
      band_nxt = BAND_G_UP;
      d_full   = t_val - T6;
    end else if (t_val < T8) begin
      band_nxt = BAND_B_DOWN;
      d_full   = T8 - t_val;
    end else if (t_val < T9) begin
      band_nxt = BAND_R_UP;
      d_full   = t_val - T8;
    end else if (t_val < T10) begin
      band_nxt = BAND_G_DOWN;
      d_full   = T10 - t_val;
    end else begin
      band_nxt = BAND_RED;
    end
  end

  always_comb begin
    ramp_prod = (PROD_W'(d_r) << 8) - PROD_W'(d_r);
    ramp      = ramp_prod[FRAC_BITS +: CHAN_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mode_r <= 1'b0;
      range_low_r  <= '1;
      range_high_r <= '0;
    end else begin
      if (cfg_wr_en) begin
        color_mode_r <= cfg_wr_data;
      end
      if (cmd.accept && in_command == CMD_MEASURE) begin
        if (in_first_pixel) begin
          range_low_r  <= inten;
          range_high_r <= inten;
        end else begin
          if (inten < range_low_r) begin
            range_low_r <= inten;
          end
          if (inten > range_high_r) begin
            range_high_r <= inten;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      rem_r <= inten - range_low_r;
      div_r <= range_high_r - range_low_r;
      if (degenerate || at_top) begin
        q_r <= Q_W'(UNIT);
      end else begin
        q_r <= '0;
      end
    end else if (cmd.div_step) begin
      q_r <= {q_r[FRAC_BITS-1:0], div_ge};
      if (div_ge) begin
        rem_r <= INTEN_W'(rem_sh - {1'b0, div_r});
      end else begin
        rem_r <= rem_sh[INTEN_W-1:0];
      end
    end

    if (cmd.band_load) begin
      band_r <= band_nxt;
      d_r    <= d_full[Q_W-1:0];
      if (band_nxt == BAND_GAUSS) begin
        rom_q_r <= GAUSS_ROM[q_r[ADDR_W-1:0]];
      end
    end

    if (cmd.out_load) begin
      case (band_r)
        BAND_GAUSS: begin
          out_red_r   <= '0;
          out_green_r <= '0;
          out_blue_r  <= rom_q_r;
        end
        BAND_G_UP: begin
          out_red_r   <= '0;
          out_green_r <= ramp;
          out_blue_r  <= '1;
        end
        BAND_B_DOWN: begin
          out_red_r   <= '0;
          out_green_r <= '1;
          out_blue_r  <= ramp;
        end
        BAND_R_UP: begin
          out_red_r   <= ramp;
          out_green_r <= '1;
          out_blue_r  <= '0;
        end
        BAND_G_DOWN: begin
          out_red_r   <= '1;
          out_green_r <= ramp;
          out_blue_r  <= '0;
        end
        default: begin
          out_red_r   <= '1;
          out_green_r <= '0;
          out_blue_r  <= '0;
        end
      endcase
    end
  end

  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

@@ tb/thermal_false_color_map_tb.sv @@
module thermal_false_color_map_tb;
  import tfcm_pkg::*;

  // Fraction width of the normalized intensity; matches the block's default.
  localparam int FRAC = 10;
  // Settling wait after the last expected color has arrived, so that any
  // word still in flight is covered.
  localparam int SETTLE_CYCLES = 20;
  // Longest output hold-off during the back-pressure test.
  localparam int HOLD_CYCLES = 300;
  // Cycles without any handshake before the run is declared hung. The slowest
  // correct stretch is one hold-off, one map word and one sender gap, so this
  // leaves a wide margin.
  localparam int STUCK_LIMIT = 2000;
  // Mismatch lines printed at most; later ones are only counted.
  localparam int PRINT_CAP = 100;

  // Same layout as out_tdata: red in the low byte, blue in the high byte.
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } rgb_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic        cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;

  // Mirror of the block's state: the measured range and the intensity mode.
  logic [9:0] span_lo;
  logic [9:0] span_hi;
  logic       mode_now;

  // Colors owed by the block, oldest first.
  rgb_t colors_due[$];

  int  words_sent;
  int  measures_sent;
  int  colors_checked;
  int  frames_run;
  int  errors;
  int  idle_cycles;
  int  burst_left;
  bit  gaps_on;
  bit  hold_req;

  thermal_false_color_map u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Color prediction
  // ---------------------------------------------------------------------------

  function automatic logic [9:0] pixel_level(input logic [7:0] r, g, b);
    logic [9:0] lvl;
    if (mode_now) begin
      lvl = 10'(r) + 10'(g) + 10'(b);
    end else begin
      lvl = 10'(3 * r);
    end
    return lvl;
  endfunction

  // Gaussian blue ramp for fractions below 0.6: a truncated exp series in Q30,
  // raised to the 256th power by eight squarings.
  function automatic logic [7:0] blue_ramp(input longint unsigned q);
    longint unsigned offs;
    longint unsigned sq;
    longint unsigned expo;
    longint unsigned z1;
    longint unsigned z2;
    longint unsigned z3;
    longint unsigned acc;
    offs = (64'd3 << FRAC) - 64'd5 * q;
    sq   = 64'd2 * offs * offs;
    if (sq >= (64'd6 << (2 * FRAC))) begin
      return 8'd0;
    end
    expo = sq << (30 - 2 * FRAC);
    z1   = expo >> 8;
    z2   = (z1 * z1) >> 30;
    z3   = (z2 * z1) >> 30;
    acc  = (64'd1 << 30) - z1 + z2 / 64'd2 - z3 / 64'd6;
    repeat (8) begin
      acc = (acc * acc) >> 30;
    end
    acc = (acc * 64'd255) >> 30;
    return acc[7:0];
  endfunction

  // Linear ramp value for a band offset d, in units of 2^-FRAC tenths.
  function automatic logic [7:0] lin_ramp(input longint unsigned d);
    longint unsigned v;
    v = (64'd255 * d) >> FRAC;
    return v[7:0];
  endfunction

  function automatic rgb_t color_for(input logic [9:0] lvl);
    longint unsigned unit;
    longint unsigned q;
    longint unsigned t;
    rgb_t c;
    unit = 64'd1 << FRAC;
    // An empty or flat range, or an intensity at the top, saturates to one.
    if (span_hi <= span_lo || lvl >= span_hi) begin
      q = unit;
    end else if (lvl <= span_lo) begin
      q = 0;
    end else begin
      q = (longint'(lvl - span_lo) << FRAC) / longint'(span_hi - span_lo);
      if (q > unit) begin
        q = unit;
      end
    end
    t = 64'd10 * q;
    c = '0;
    if (t < 6 * unit) begin
      c.blue = blue_ramp(q);
    end else if (t < 7 * unit) begin
      c.green = lin_ramp(t - 6 * unit);
      c.blue  = 8'd255;
    end else if (t < 8 * unit) begin
      c.green = 8'd255;
      c.blue  = lin_ramp(8 * unit - t);
    end else if (t < 9 * unit) begin
      c.red   = lin_ramp(t - 8 * unit);
      c.green = 8'd255;
    end else if (q < unit) begin
      c.red   = 8'd255;
      c.green = lin_ramp(10 * unit - t);
    end else begin
      c.red = 8'd255;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // Reporting and checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= PRINT_CAP) begin
      $display("[%0t] MISMATCH: %s", $realtime, what);
    end
  endtask

  task automatic check_field(input string name, input int idx,
                             input logic [7:0] got, input logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("color %0d %s: got %0d, expected %0d",
                                idx, name, got, want));
    end
  endtask

  // Each accepted output word is compared with the oldest owed color.
  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (colors_due.size() == 0) begin
        report_mismatch($sformatf("unexpected output word 0x%06h", out_tdata));
      end else begin
        want = colors_due.pop_front();
        check_field("red", colors_checked, got.red, want.red);
        check_field("green", colors_checked, got.green, want.green);
        check_field("blue", colors_checked, got.blue, want.blue);
        colors_checked++;
      end
    end
  end

  // Hang detection: any handshake on either side resets the count.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STUCK_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", STUCK_LIMIT);
        $display("simulation failed");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: segments of random length, each with its own stall pattern,
  // plus one long hold-off on request.
  // ---------------------------------------------------------------------------

  initial begin
    int seg_left;
    int seg_mode;
    int hold_left;
    int tick;
    seg_left   = 0;
    seg_mode   = 0;
    hold_left  = 0;
    tick       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      tick++;
      if (hold_left > 0) begin
        out_tready = 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req   = 1'b0;
        hold_left  = HOLD_CYCLES - 1;
        out_tready = 1'b0;
      end else begin
        if (seg_left == 0) begin
          seg_mode = $urandom_range(0, 3);
          seg_left = $urandom_range(8, 80);
        end
        seg_left--;
        case (seg_mode)
          0: begin
            out_tready = 1'b1;
          end
          1: begin
            out_tready = 1'($urandom_range(0, 1));
          end
          2: begin
            out_tready = ($urandom_range(0, 4) != 0);
          end
          default: begin
            out_tready = ((tick % 7) < 2);
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one word, waits for it to be taken and updates the prediction.
  // Returns at a falling edge; tvalid stays high when the burst goes on, so a
  // caller that lets time pass before the next word must lower it first.
  task automatic send_word(input logic cmd, input logic first,
                           input logic [7:0] r, input logic [7:0] g,
                           input logic [7:0] b);
    logic [9:0] lvl;
    in_tvalid = 1'b1;
    in_tuser  = {first, cmd};
    in_tdata  = {b, g, r};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    words_sent++;
    lvl = pixel_level(r, g, b);
    if (cmd == CMD_MEASURE) begin
      measures_sent++;
      if (first) begin
        span_lo = lvl;
        span_hi = lvl;
      end else begin
        if (lvl < span_lo) begin
          span_lo = lvl;
        end
        if (lvl > span_hi) begin
          span_hi = lvl;
        end
      end
    end else begin
      colors_due.push_back(color_for(lvl));
    end
    @(negedge clk);
    if (gaps_on) begin
      if (burst_left == 0) begin
        in_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        burst_left = $urandom_range(0, 15);
      end else begin
        burst_left--;
      end
    end
  endtask

  // Lets every owed color arrive, then waits out the settling time for any word
  // that produces nothing. Returns at a falling edge with the input idle.
  task automatic wait_idle();
    in_tvalid = 1'b0;
    while (colors_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    wait_idle();
    cfg_wr_en   = 1'b1;
    cfg_wr_data = m;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    mode_now    = m;
  endtask

  function automatic logic [7:0] near(input int center, input int spread);
    int v;
    v = center - spread + $urandom_range(0, 2 * spread);
    if (v < 0) begin
      v = 0;
    end
    if (v > 255) begin
      v = 255;
    end
    return v[7:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Straight out of reset no range has been measured, so every map word is
  // pure red, and a first-pixel flag on a map word changes nothing.
  task automatic test_unmeasured_range();
    send_word(CMD_MAP, 1'b0, 8'd255, 8'd0, 8'd0);
    send_word(CMD_MAP, 1'b1, 8'd0, 8'd255, 8'd255);
  endtask

  // Grey mode over the full range 0..765, with red values chosen to land in
  // and on the edges of every color band.
  task automatic test_grey_bands();
    logic [7:0] reds[12];
    reds = '{8'd0, 8'd100, 8'd153, 8'd154, 8'd170, 8'd180,
             8'd190, 8'd204, 8'd215, 8'd230, 8'd250, 8'd255};
    write_mode(1'b0);
    // A single measured pixel gives a flat range: pure red.
    send_word(CMD_MEASURE, 1'b1, 8'd0, 8'd77, 8'd200);
    send_word(CMD_MAP, 1'b0, 8'd0, 8'd0, 8'd0);
    send_word(CMD_MEASURE, 1'b0, 8'd255, 8'd0, 8'd0);
    foreach (reds[i]) begin
      send_word(CMD_MAP, 1'b0, reds[i], 8'($urandom), 8'($urandom));
    end
    send_word(CMD_MAP, 1'b1, 8'd128, 8'd0, 8'd0);
  endtask

  // Color mode: a range that starts above zero, so a black pixel falls below
  // it, and a white pixel reaches the largest possible intensity.
  task automatic test_color_extremes();
    write_mode(1'b1);
    send_word(CMD_MEASURE, 1'b1, 8'd10, 8'd20, 8'd30);
    send_word(CMD_MEASURE, 1'b0, 8'd255, 8'd255, 8'd255);
    send_word(CMD_MAP, 1'b0, 8'd0, 8'd0, 8'd0);
    send_word(CMD_MAP, 1'b0, 8'd255, 8'd255, 8'd255);
    send_word(CMD_MAP, 1'b0, 8'd0, 8'd255, 8'd0);
    send_word(CMD_MAP, 1'b0, 8'd0, 8'd0, 8'd255);
  endtask

  // The receiver holds off for a long stretch while map words keep coming
  // back to back, so the block fills up and must stall its input.
  task automatic test_output_stall();
    int i;
    write_mode(1'b1);
    gaps_on = 1'b0;
    send_word(CMD_MEASURE, 1'b1, 8'd40, 8'd0, 8'd0);
    for (i = 0; i < 7; i++) begin
      send_word(CMD_MEASURE, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    hold_req = 1'b1;
    for (i = 0; i < 40; i++) begin
      send_word(CMD_MAP, 1'b0, 8'($urandom), 8'($urandom), 8'($urandom));
    end
    gaps_on = 1'b1;
  endtask

  // Random frames: a measure pass that restarts the range on its first pixel,
  // then a map pass over the same pixels with a few strays. Some frames are
  // broken: no restart, a restart in mid-pass, or map words before the
  // measure pass. The mode is rewritten at random between frames while the block is idle.
  task automatic test_random_frames(input int target);
    logic [7:0] pr[120];
    logic [7:0] pg[120];
    logic [7:0] pb[120];
    int stop_at;
    int n;
    int i;
    int k;
    int center;
    int spread;
    bit no_restart;
    stop_at = words_sent + target;
    while (words_sent < stop_at) begin
      write_mode(1'($urandom_range(0, 1)));
      gaps_on    = ($urandom_range(0, 3) != 0);
      n          = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(2, 24);
      center     = $urandom_range(0, 255);
      case ($urandom_range(0, 5))
        0: spread = 0;
        1: spread = 1;
        2: spread = 3;
        3: spread = 10;
        4: spread = 60;
        default: spread = 255;
      endcase
      no_restart = ($urandom_range(0, 9) == 0);
      for (i = 0; i < n; i++) begin
        pr[i] = near(center, spread);
        pg[i] = near(center, spread);
        pb[i] = near(center, spread);
      end
      // Map words against whatever range the previous frame left behind.
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 3)) begin
          send_word(CMD_MAP, 1'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
      end
      for (i = 0; i < n; i++) begin
        send_word(CMD_MEASURE,
                  (i == 0 && !no_restart) || ($urandom_range(0, 39) == 0),
                  pr[i], pg[i], pb[i]);
      end
      for (i = 0; i < n; i++) begin
        k = ($urandom_range(0, 1) == 0) ? i : $urandom_range(0, n - 1);
        if ($urandom_range(0, 7) == 0) begin
          send_word(CMD_MAP, $urandom_range(0, 15) == 0,
                    8'($urandom), 8'($urandom), 8'($urandom));
        end else begin
          send_word(CMD_MAP, $urandom_range(0, 15) == 0, pr[k], pg[k], pb[k]);
        end
      end
      frames_run++;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_n          = 1'b0;
    cfg_wr_en      = 1'b0;
    cfg_wr_data    = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    in_tuser       = '0;
    span_lo        = 10'd1023;
    span_hi        = 10'd0;
    mode_now       = 1'b0;
    words_sent     = 0;
    measures_sent  = 0;
    colors_checked = 0;
    frames_run     = 0;
    errors         = 0;
    idle_cycles    = 0;
    burst_left     = 0;
    gaps_on        = 1'b1;
    hold_req       = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_unmeasured_range();
    test_grey_bands();
    test_color_extremes();
    test_output_stall();
    test_random_frames(1880);

    wait_idle();
    if (colors_due.size() != 0) begin
      report_mismatch($sformatf("%0d colors never arrived", colors_due.size()));
    end
    $display("covered %0d words (%0d measure, %0d colors checked) in %0d random frames,",
             words_sent, measures_sent, colors_checked, frames_run);
    $display("both modes, all bands, flat and empty ranges, a long stall; %0d mismatches",
             errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ thermal_false_color_map.f @@
hw/rtl/tfcm_pkg.sv
hw/rtl/tfcm_ctrl.sv
hw/rtl/tfcm_datapath.sv
hw/rtl/thermal_false_color_map.sv
tb/thermal_false_color_map_tb.sv
